// File: hw/rtl/fdl_pkg.sv
// shared types, constants and codes for the fractional delay line
package fdl_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS  = 16;
    localparam int FRAC_BITS    = 16;
    localparam int DELAY_BITS   = 24;
    localparam int INT_BITS     = DELAY_BITS - FRAC_BITS;
    localparam int CFG_IDX_BITS = 2;

    // default history depth in samples
    localparam int DEF_BUFFER_DEPTH = 256;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE       = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_INIT_DELAY = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_DELAY  = 2'd2;

    // operating modes
    typedef enum logic [1:0] {
        MODE_BYPASS,
        MODE_FIXED,
        MODE_DYNAMIC,
        MODE_GATED
    } fdl_mode_t;

    // register reset values
    localparam fdl_mode_t               MODE_RESET       = MODE_FIXED;
    localparam logic [DELAY_BITS-1:0]   INIT_DELAY_RESET = 24'h000000;
    localparam logic [DELAY_BITS-1:0]   MAX_DELAY_RESET  = 24'hFF0000;

    // input item
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic [DELAY_BITS-1:0]         new_delay;
        logic                          block_start;
        logic                          change_enable;
    } fdl_in_t;

    // result item
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          delay_error;
    } fdl_out_t;

    // per-item control handed from the address stage to the interpolator
    typedef struct packed {
        logic                          pass;
        logic                          use_input;
        logic                          err;
        logic [FRAC_BITS-1:0]          frac;
        logic signed [SAMPLE_BITS-1:0] sample;
    } fdl_issue_t;

endpackage

// File: hw/rtl/fdl_ram.sv
// generic single-write, single-read ram with registered read data
module fdl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first: a read of the entry being written returns the old data
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

endmodule

// File: hw/rtl/fdl_ctrl.sv
// configuration, delay selection, history clearing and address generation
module fdl_ctrl #(
    parameter int BUFFER_DEPTH = fdl_pkg::DEF_BUFFER_DEPTH,
    localparam int AW          = $clog2(BUFFER_DEPTH)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [fdl_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [fdl_pkg::DELAY_BITS-1:0]      cfg_wdata,
    input  logic                                s_valid,
    input  fdl_pkg::fdl_in_t                    s_data,
    input  logic                                pipe_ready,
    output logic                                s_ready,
    output logic                                accept,
    output logic                                ram_we,
    output logic [AW-1:0]                       ram_waddr,
    output logic [fdl_pkg::SAMPLE_BITS-1:0]     ram_wdata,
    output logic [AW-1:0]                       ram_raddr_left,
    output logic [AW-1:0]                       ram_raddr_right,
    output fdl_pkg::fdl_issue_t                 issue
);
    import fdl_pkg::*;

    fdl_mode_t             mode_reg;
    logic [DELAY_BITS-1:0] max_delay_reg;
    logic [DELAY_BITS-1:0] active_delay_reg;
    logic [DELAY_BITS-1:0] active_delay_next;
    logic [AW-1:0]         write_index_reg;
    logic [AW-1:0]         write_index_next;
    logic                  clearing_reg;
    logic [AW-1:0]         clear_addr_reg;

    logic                  load;
    logic                  over;
    logic [DELAY_BITS-1:0] act;
    logic [DELAY_BITS-1:0] eff;
    logic [INT_BITS-1:0]   d_int;
    logic [AW-1:0]         d_mod;
    logic [AW:0]           diff;
    logic [AW:0]           right_wide;
    logic [AW-1:0]         right_idx;

    // integer delay modulo the depth, built at elaboration
    logic [AW-1:0] mod_tab [2**INT_BITS];
    for (genvar g = 0; g < 2**INT_BITS; g++) begin : g_mod
        assign mod_tab[g] = AW'(g % BUFFER_DEPTH);
    end

    // handshake
    assign s_ready = pipe_ready && !clearing_reg;
    assign accept  = s_valid && s_ready;

    // delay actually used by this item
    always_comb begin
        load = s_data.block_start &&
               ((mode_reg == MODE_DYNAMIC) ||
                ((mode_reg == MODE_GATED) && s_data.change_enable));
        act  = load ? s_data.new_delay : active_delay_reg;
        over = act > max_delay_reg;
        eff  = over ? max_delay_reg : act;
        d_int = eff[DELAY_BITS-1:FRAC_BITS];
        d_mod = mod_tab[d_int];
    end

    // control for the interpolator
    always_comb begin
        issue.pass      = (mode_reg == MODE_BYPASS) || (act == '0);
        issue.use_input = (d_int == '0);
        issue.err       = !issue.pass && over;
        issue.frac      = eff[FRAC_BITS-1:0];
        issue.sample    = s_data.sample_in;
    end

    // read addresses: right tap at write_index - d, left tap one older
    always_comb begin
        diff       = {1'b0, write_index_reg} - {1'b0, d_mod};
        right_wide = diff[AW] ? diff + (AW+1)'(BUFFER_DEPTH) : diff;
        right_idx  = right_wide[AW-1:0];
        ram_raddr_right = right_idx;
        ram_raddr_left  = (right_idx == '0) ? AW'(BUFFER_DEPTH - 1) : right_idx - 1'b1;
    end

    // history write: zero sweep after reset, then one sample per item
    always_comb begin
        ram_we    = clearing_reg || accept;
        ram_waddr = clearing_reg ? clear_addr_reg : write_index_reg;
        ram_wdata = clearing_reg ? '0 : s_data.sample_in;
    end

    // next values of the delay and the write pointer
    always_comb begin
        active_delay_next = active_delay_reg;
        write_index_next  = write_index_reg;
        if (cfg_we && (cfg_index == REG_INIT_DELAY)) begin
            active_delay_next = cfg_wdata;
        end else if (accept && (mode_reg != MODE_BYPASS) && load) begin
            active_delay_next = s_data.new_delay;
        end
        if (accept) begin
            write_index_next = (write_index_reg == AW'(BUFFER_DEPTH - 1)) ?
                               '0 : write_index_reg + 1'b1;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_RESET;
            max_delay_reg    <= MAX_DELAY_RESET;
            active_delay_reg <= INIT_DELAY_RESET;
            write_index_reg  <= '0;
            clearing_reg     <= 1'b1;
            clear_addr_reg   <= '0;
        end else begin
            active_delay_reg <= active_delay_next;
            write_index_reg  <= write_index_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_MODE:      mode_reg      <= fdl_mode_t'(cfg_wdata[1:0]);
                    REG_MAX_DELAY: max_delay_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (clearing_reg) begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
                if (clear_addr_reg == AW'(BUFFER_DEPTH - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
        end
    end

endmodule

// File: hw/rtl/fdl_interp.sv
// interpolation pipeline: multiply, round and saturate, output register
module fdl_interp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  fdl_pkg::fdl_issue_t             issue,
    input  logic [fdl_pkg::SAMPLE_BITS-1:0] left_data,
    input  logic [fdl_pkg::SAMPLE_BITS-1:0] right_data,
    output logic                            pipe_ready,
    output logic                            m_valid,
    input  logic                            m_ready,
    output fdl_pkg::fdl_out_t               m_data
);
    import fdl_pkg::*;

    localparam int ACC_W = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int Q_W   = SAMPLE_BITS + 2;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [Q_W-1:0]   SMAX = Q_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Q_W-1:0]   SMIN = -SMAX - Q_W'(1);

    // stage 1: ram data arrives
    logic                          v1_reg;
    fdl_issue_t                    iss1_reg;
    // stage 2: product registered
    logic                          v2_reg;
    logic signed [ACC_W-1:0]       prod2_reg;
    logic signed [SAMPLE_BITS-1:0] right2_reg;
    logic signed [SAMPLE_BITS-1:0] sample2_reg;
    logic                          pass2_reg;
    logic                          err2_reg;
    // output
    logic                          m_valid_reg;
    fdl_out_t                      m_data_reg;
    fdl_out_t                      m_data_next;

    logic en_out, en2, en1;
    logic signed [SAMPLE_BITS-1:0] right1;
    logic signed [SAMPLE_BITS:0]   diff1;
    logic signed [FRAC_BITS:0]     frac1;
    logic signed [ACC_W-1:0]       prod1;
    logic signed [ACC_W-1:0]       acc2;
    logic signed [ACC_W-1:0]       shifted2;
    logic signed [Q_W-1:0]         q2;
    logic signed [SAMPLE_BITS-1:0] sat2;

    // stall chain
    assign en_out     = !m_valid_reg || m_ready;
    assign en2        = !v2_reg || en_out;
    assign en1        = !v1_reg || en2;
    assign pipe_ready = en1;

    // stage 1: y = right + f * (left - right)
    always_comb begin
        right1 = iss1_reg.use_input ? iss1_reg.sample : $signed(right_data);
        diff1  = (SAMPLE_BITS+1)'($signed(left_data)) - (SAMPLE_BITS+1)'(right1);
        frac1  = $signed({1'b0, iss1_reg.frac});
        prod1  = ACC_W'(frac1) * ACC_W'(diff1);
    end

    // stage 2: add, round half up, floor shift, saturate
    always_comb begin
        acc2     = (ACC_W'(right2_reg) <<< FRAC_BITS) + prod2_reg + HALF;
        shifted2 = acc2 >>> FRAC_BITS;
        q2       = shifted2[Q_W-1:0];
        if (q2 > SMAX) begin
            sat2 = SMAX[SAMPLE_BITS-1:0];
        end else if (q2 < SMIN) begin
            sat2 = SMIN[SAMPLE_BITS-1:0];
        end else begin
            sat2 = q2[SAMPLE_BITS-1:0];
        end
        m_data_next.sample_out  = pass2_reg ? sample2_reg : sat2;
        m_data_next.delay_error = err2_reg;
    end

    // pipeline registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= accept;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en_out) begin
                m_valid_reg <= v2_reg;
            end
        end
        if (accept) begin
            iss1_reg <= issue;
        end
        if (en2 && v1_reg) begin
            prod2_reg   <= prod1;
            right2_reg  <= right1;
            sample2_reg <= iss1_reg.sample;
            pass2_reg   <= iss1_reg.pass;
            err2_reg    <= iss1_reg.err;
        end
        if (en_out && v2_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: hw/rtl/fractional_delay_line.sv
// fractional delay line with linear interpolation, one sample in, one sample out
// from input accept to result valid: ram read, multiply, round, each step registered
// throughput: one item per cycle unless stalled; each history ram read once per item
// reset: synchronous active-low; registers take their reset values, then a clearing
// sweep zeroes the history with s_ready low (config writes taken)
module fractional_delay_line #(
    parameter int BUFFER_DEPTH = fdl_pkg::DEF_BUFFER_DEPTH,
    localparam int AW          = $clog2(BUFFER_DEPTH)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [fdl_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [fdl_pkg::DELAY_BITS-1:0]   cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  fdl_pkg::fdl_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output fdl_pkg::fdl_out_t                m_data
);
    import fdl_pkg::*;

    logic                   pipe_ready;
    logic                   accept;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [AW-1:0]          raddr_left;
    logic [AW-1:0]          raddr_right;
    logic [SAMPLE_BITS-1:0] left_data;
    logic [SAMPLE_BITS-1:0] right_data;
    fdl_issue_t             issue;

    // delay selection and addressing
    fdl_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_data          (s_data),
        .pipe_ready      (pipe_ready),
        .s_ready         (s_ready),
        .accept          (accept),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata),
        .ram_raddr_left  (raddr_left),
        .ram_raddr_right (raddr_right),
        .issue           (issue)
    );

    // history copy for the older tap
    fdl_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram_left (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (raddr_left),
        .rdata (left_data)
    );

    // history copy for the newer tap
    fdl_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram_right (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (raddr_right),
        .rdata (right_data)
    );

    // interpolation datapath
    fdl_interp u_interp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .issue      (issue),
        .left_data  (left_data),
        .right_data (right_data),
        .pipe_ready (pipe_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// File: hw/rtl/fdl_checker.sv
// port-level checks for the fractional delay line, bound to the top level
module fdl_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input fdl_pkg::fdl_out_t m_data
);
    import fdl_pkg::*;

    localparam logic [2:0] PIPE_STAGES = 3'd3;

    logic [2:0] pending_reg;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;

    // items accepted but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + {2'b00, in_fire} - {2'b00, out_fire};
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // history clear keeps the input closed right after reset
    a_clear_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !s_ready)
        else $error("input accepted during history clear");

    // no result without an accepted item
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 3'd0)
        else $error("result without a pending item");

    // never more items in flight than pipeline stages
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= PIPE_STAGES)
        else $error("too many items in flight");

endmodule

bind fractional_delay_line fdl_checker u_fdl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: bench/fractional_delay_line_test.sv
// self-checking testbench for the fractional delay line: directed cases, then random traffic
`timescale 1ns / 100ps

module fractional_delay_line_test;
    import fdl_pkg::*;

    localparam int DEPTH       = DEF_BUFFER_DEPTH;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 8;

    // index with no register behind it
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = REG_MODE;
    logic [DELAY_BITS-1:0]   cfg_wdata = '0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    fdl_in_t                 s_data    = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    fdl_out_t                m_data;

    // idling controls, in percent
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // mirror of the block state
    logic signed [SAMPLE_BITS-1:0] line_hist [DEPTH];
    logic [7:0]                    line_wr_ptr;
    logic [DELAY_BITS-1:0]         line_delay;
    fdl_mode_t                     line_mode;
    logic [DELAY_BITS-1:0]         line_init_delay;
    logic [DELAY_BITS-1:0]         line_max_delay;

    fdl_out_t pending_samples [$];

    fractional_delay_line i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // register write into the mirror
    function automatic void mirror_reg_write(logic [CFG_IDX_BITS-1:0] idx,
                                             logic [DELAY_BITS-1:0] value);
        if (idx == REG_MODE) begin
            line_mode = fdl_mode_t'(value[1:0]);
        end else if (idx == REG_INIT_DELAY) begin
            line_init_delay = value;
            line_delay      = value;
        end else if (idx == REG_MAX_DELAY) begin
            line_max_delay = value;
        end
    endfunction

    // interpolated output for one accepted item, advances the mirror
    function automatic fdl_out_t interpolate_sample(fdl_in_t item);
        fdl_out_t              res;
        logic [DELAY_BITS-1:0] eff;
        logic [7:0]            whole;
        logic [FRAC_BITS-1:0]  frac;
        logic [7:0]            older_idx;
        logic [7:0]            newer_idx;
        longint                older;
        longint                newer;
        longint                acc;
        res.delay_error = 1'b0;
        res.sample_out  = item.sample_in;
        if (line_mode != MODE_BYPASS) begin
            if (item.block_start && (line_mode == MODE_DYNAMIC ||
                                     (line_mode == MODE_GATED && item.change_enable))) begin
                line_delay = item.new_delay;
            end
            if (line_delay != '0) begin
                eff = line_delay;
                if (eff > line_max_delay) begin
                    eff             = line_max_delay;
                    res.delay_error = 1'b1;
                end
                whole     = eff[DELAY_BITS-1:FRAC_BITS];
                frac      = eff[FRAC_BITS-1:0];
                // read positions wrap with the 8-bit pointer
                older_idx = line_wr_ptr - 8'd1 - whole;
                newer_idx = line_wr_ptr - whole;
                older     = line_hist[older_idx];
                newer     = (whole == 8'd0) ? longint'(item.sample_in) : line_hist[newer_idx];
                acc = longint'(frac) * older + (longint'(1 << FRAC_BITS) - longint'(frac)) * newer
                      + longint'(1 << (FRAC_BITS - 1));
                acc = acc >>> FRAC_BITS;
                if (acc > 32767) acc = 32767;
                if (acc < -32768) acc = -32768;
                res.sample_out = acc[SAMPLE_BITS-1:0];
            end
        end
        line_hist[line_wr_ptr] = item.sample_in;
        line_wr_ptr            = line_wr_ptr + 8'd1;
        return res;
    endfunction

    // result check, then prediction for the item accepted at this edge
    always @(posedge aclk) begin
        fdl_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_samples.size() == 0) begin
                    $error("result item arrived with none expected");
                    error_count++;
                end else begin
                    want = pending_samples.pop_front();
                    if (want.sample_out !== m_data.sample_out) begin
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               want.sample_out, m_data.sample_out);
                        error_count++;
                    end
                    if (want.delay_error !== m_data.delay_error) begin
                        $error("delay_error mismatch: expected %0b, actual %0b",
                               want.delay_error, m_data.delay_error);
                        error_count++;
                    end
                end
            end
            if (cfg_we) begin
                mirror_reg_write(cfg_index, cfg_wdata);
            end
            if (s_valid && s_ready) begin
                pending_samples.push_back(interpolate_sample(s_data));
            end
        end
    end

    function automatic fdl_in_t make_item(logic signed [SAMPLE_BITS-1:0] smp,
                                          logic [DELAY_BITS-1:0] dly,
                                          logic start, logic enable);
        fdl_in_t item;
        item.sample_in     = smp;
        item.new_delay     = dly;
        item.block_start   = start;
        item.change_enable = enable;
        return item;
    endfunction

    // one configuration write, with cfg_we low again before the task returns
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [DELAY_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    // present one item, with a random gap ahead of it
    task automatic send_item(fdl_in_t item);
        logic [63:0] junk;
        while ($urandom_range(99) < send_idle_pct) begin
            junk    = {$urandom(), $urandom()};
            s_valid <= 1'b0;
            s_data  <= junk[$bits(fdl_in_t)-1:0];
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_until_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // defaults after reset: fixed mode, zero delay passes samples through
    task automatic test_reset_state();
        send_item(make_item(16'sh7FFF, 24'hFFFFFF, 1'b1, 1'b1));
        send_item(make_item(16'sh8000, 24'h000000, 1'b0, 1'b0));
        send_item(make_item(-16'sd1, 24'h123456, 1'b1, 1'b0));
        wait_until_idle();
    endtask

    // bypass ignores delay and limit; upper mode bits are dropped
    task automatic test_bypass();
        write_reg(REG_MODE, 24'hFFFFFC);
        write_reg(REG_INIT_DELAY, 24'h030000);
        write_reg(REG_MAX_DELAY, 24'h010000);
        send_item(make_item(16'sh1234, 24'hFFFFFF, 1'b1, 1'b1));
        send_item(make_item(16'sh8000, 24'h000000, 1'b0, 1'b1));
        send_item(make_item(16'sh7FFF, 24'h020000, 1'b1, 1'b0));
        wait_until_idle();
    endtask

    // fixed delay: half-sample step, wrap at full depth, clamp above the limit
    task automatic test_fixed_delay();
        write_reg(REG_MODE, 24'h5A5A51);
        write_reg(REG_MAX_DELAY, 24'hFFFFFF);
        write_reg(REG_INIT_DELAY, 24'h018000);
        send_item(make_item(16'sh7FFF, 24'h000000, 1'b1, 1'b1));
        send_item(make_item(16'sh8000, 24'h000000, 1'b0, 1'b0));
        send_item(make_item(16'sh0001, 24'h000000, 1'b0, 1'b0));
        send_item(make_item(-16'sd3, 24'h000000, 1'b0, 1'b0));
        wait_until_idle();
        write_reg(REG_INIT_DELAY, 24'hFFFFFF);
        send_item(make_item(16'sh4000, 24'h000000, 1'b0, 1'b0));
        send_item(make_item(16'shC000, 24'h000000, 1'b0, 1'b0));
        wait_until_idle();
        write_reg(REG_MAX_DELAY, 24'h008000);
        write_reg(REG_INIT_DELAY, 24'h020000);
        send_item(make_item(16'sh0100, 24'h000000, 1'b0, 1'b0));
        send_item(make_item(16'sh7FFF, 24'h000000, 1'b0, 1'b0));
        wait_until_idle();
        // limit of zero with a nonzero delay: clamped to zero delay, delay_error set
        write_reg(REG_MAX_DELAY, 24'h000000);
        send_item(make_item(16'sh2222, 24'h000000, 1'b0, 1'b0));
        wait_until_idle();
    endtask

    // dynamic: load on block start, effective on that same item
    task automatic test_dynamic_delay();
        write_reg(REG_MODE, {22'd0, MODE_DYNAMIC});
        write_reg(REG_MAX_DELAY, MAX_DELAY_RESET);
        send_item(make_item(16'sh7FFF, 24'h00C000, 1'b1, 1'b0));
        send_item(make_item(16'sh8000, 24'h050000, 1'b0, 1'b1));
        send_item(make_item(16'sh1357, 24'h000000, 1'b1, 1'b0));
        send_item(make_item(16'sh0ACE, 24'hFFFFFF, 1'b1, 1'b1));
        send_item(make_item(-16'sd2, 24'h000000, 1'b0, 1'b0));
        wait_until_idle();
    endtask

    // gated: load only with both block start and change enable
    task automatic test_gated_delay();
        write_reg(REG_MODE, 24'hFFFFFF);
        send_item(make_item(16'sh7FFF, 24'h010000, 1'b1, 1'b1));
        send_item(make_item(16'sh8000, 24'h050000, 1'b1, 1'b0));
        send_item(make_item(16'sh0F0F, 24'h000000, 1'b0, 1'b1));
        send_item(make_item(16'sh7001, 24'h000000, 1'b1, 1'b1));
        wait_until_idle();
    endtask

    function automatic logic [DELAY_BITS-1:0] pick_delay();
        logic [DELAY_BITS-1:0] dly;
        case ($urandom_range(9))
            0:       dly = '0;
            1:       dly = 24'hFFFFFF;
            2:       dly = line_max_delay + DELAY_BITS'($urandom_range(2)) - 24'd1;
            3, 4, 5: dly = {8'($urandom_range(7)), 16'($urandom())};
            6:       dly = {8'($urandom_range(250, 255)), 16'($urandom())};
            default: dly = DELAY_BITS'($urandom());
        endcase
        return dly;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        logic signed [SAMPLE_BITS-1:0] smp;
        case ($urandom_range(7))
            0:       smp = 16'sh7FFF;
            1:       smp = 16'sh8000;
            default: smp = SAMPLE_BITS'($urandom());
        endcase
        return smp;
    endfunction

    // new register set, extremes included
    task automatic random_config();
        logic [DELAY_BITS-1:0] lim;
        write_reg(REG_MODE, DELAY_BITS'($urandom()));
        case ($urandom_range(4))
            0:       lim = '0;
            1:       lim = 24'hFFFFFF;
            2:       lim = MAX_DELAY_RESET;
            3:       lim = {8'($urandom_range(7)), 16'($urandom())};
            default: lim = DELAY_BITS'($urandom());
        endcase
        write_reg(REG_MAX_DELAY, lim);
        write_reg(REG_INIT_DELAY, pick_delay());
        // the spare index must change nothing
        if ($urandom_range(7) == 0) begin
            write_reg(REG_SPARE, DELAY_BITS'($urandom()));
        end
    endtask

    // random blocks of samples under one idling profile
    task automatic test_random_traffic(int unsigned n_items, int unsigned idle_pct,
                                       int unsigned stall_pct);
        int unsigned sent;
        int unsigned group;
        sent           = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < n_items) begin
            random_config();
            group = $urandom_range(20, 80);
            repeat (group) begin
                send_item(make_item(pick_sample(), pick_delay(),
                                    ($urandom_range(7) == 0), 1'($urandom_range(1))));
                sent++;
            end
            wait_until_idle();
        end
    endtask

    initial begin
        line_wr_ptr     = '0;
        line_mode       = MODE_RESET;
        line_init_delay = INIT_DELAY_RESET;
        line_max_delay  = MAX_DELAY_RESET;
        line_delay      = INIT_DELAY_RESET;
        for (int i = 0; i < DEPTH; i++) line_hist[i] = '0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct  = 30;
        recv_stall_pct = 30;
        test_reset_state();
        test_bypass();
        test_fixed_delay();
        test_dynamic_delay();
        test_gated_delay();

        test_random_traffic(475, 0, 0);
        test_random_traffic(475, 77, 0);
        test_random_traffic(475, 0, 77);
        test_random_traffic(475, 24, 24);

        wait_until_idle();
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: fractional_delay_line.f
hw/rtl/fdl_pkg.sv
hw/rtl/fdl_ram.sv
hw/rtl/fdl_ctrl.sv
hw/rtl/fdl_interp.sv
hw/rtl/fractional_delay_line.sv
hw/rtl/fdl_checker.sv
bench/fractional_delay_line_test.sv
